// File: rtl/alg3d_pkg.sv
package alg3d_pkg;

   localparam int CORDIC_ITERS = 28;
   localparam int MUL_STEPS = 64;
   localparam logic signed [31:0] PI_Q28 = 32'sd843314857;
   localparam logic [29:0] INV_GAIN = 30'd652032874;

   typedef enum logic [2:0] {
      REG_LOOKAHEAD_H,
      REG_LOOKAHEAD_V,
      REG_GAIN_H,
      REG_GAIN_V,
      REG_STEP
   } reg_index_type;

   typedef struct packed {
      logic signed [31:0] prev_x;
      logic signed [31:0] prev_y;
      logic signed [31:0] prev_z;
      logic signed [31:0] next_x;
      logic signed [31:0] next_y;
      logic signed [31:0] next_z;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] heading_desired;
      logic signed [31:0] pitch_desired;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      S_IDLE, S_HCHK, S_HINIT, S_VCHK, S_VINIT, S_LHCHK, S_LHINIT, S_LVCHK,
      S_LVINIT, S_ROT, S_ZSTORE, S_MSTART, S_MSTEP, S_MSTORE, S_OUTW
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_H_INIT, OP_V_INIT, OP_LH_INIT, OP_LV_INIT, OP_ROT,
      OP_MUL_START, OP_MUL_STEP, OP_STORE, OP_OUT
   } op_type;

   typedef enum logic [3:0] {
      DST_PIH, DST_PIV, DST_PHIH, DST_PHIV, DST_RH, DST_XP, DST_YE, DST_ZE,
      DST_TH, DST_TV, DST_AH, DST_AV, DST_LH_ZERO, DST_LV_ZERO
   } dst_type;

   typedef enum logic [1:0] {RJ_H, RJ_V, RJ_LH, RJ_LV} rot_job_type;

   typedef struct packed {
      op_type     op;
      logic [4:0] idx;
      dst_type    dst;
   } cmd_type;

   typedef struct packed {
      logic h_zero;
      logic v_skip;
      logic lh_zero;
      logic lv_zero;
      logic out_free;
   } status_type;

   function automatic logic signed [31:0] atan_q28(input logic [4:0] i);
      logic signed [31:0] r;
      case (i)
         5'd0: r = 32'sd210828714;
         5'd1: r = 32'sd124459457;
         5'd2: r = 32'sd65760959;
         5'd3: r = 32'sd33381290;
         5'd4: r = 32'sd16755422;
         5'd5: r = 32'sd8385879;
         5'd6: r = 32'sd4193963;
         5'd7: r = 32'sd2097109;
         5'd8: r = 32'sd1048571;
         5'd9: r = 32'sd524287;
         5'd10: r = 32'sd262144;
         5'd11: r = 32'sd131072;
         5'd12: r = 32'sd65536;
         5'd13: r = 32'sd32768;
         5'd14: r = 32'sd16384;
         5'd15: r = 32'sd8192;
         5'd16: r = 32'sd4096;
         5'd17: r = 32'sd2048;
         5'd18: r = 32'sd1024;
         5'd19: r = 32'sd512;
         5'd20: r = 32'sd256;
         5'd21: r = 32'sd128;
         5'd22: r = 32'sd64;
         5'd23: r = 32'sd32;
         5'd24: r = 32'sd16;
         5'd25: r = 32'sd8;
         5'd26: r = 32'sd4;
         5'd27: r = 32'sd2;
         default: r = 32'sd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sd2147483647) r = 32'sh7FFF_FFFF;
      else if (v < -34'sd2147483648) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

// File: rtl/alg3d_ctrl.sv
module alg3d_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  alg3d_pkg::status_type status,
   output alg3d_pkg::cmd_type    cmd
);
   import alg3d_pkg::*;

   state_type   state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;
   rot_job_type rjob_ff, rjob_in;
   dst_type     mdst_ff, mdst_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         rjob_ff  <= RJ_H;
         mdst_ff  <= DST_RH;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rjob_ff  <= rjob_in;
         mdst_ff  <= mdst_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rjob_in  = rjob_ff;
      mdst_in  = mdst_ff;
      case (state_ff)
         S_IDLE: if (req_valid) state_in = S_HCHK;
         S_HCHK: state_in = status.h_zero ? S_VCHK : S_HINIT;
         S_HINIT: begin
            rjob_in = RJ_H; cnt_in = '0; state_in = S_ROT;
         end
         S_VCHK: state_in = status.v_skip ? S_LHCHK : S_VINIT;
         S_VINIT: begin
            rjob_in = RJ_V; cnt_in = '0; state_in = S_ROT;
         end
         S_LHCHK: state_in = status.lh_zero ? S_LVCHK : S_LHINIT;
         S_LHINIT: begin
            rjob_in = RJ_LH; cnt_in = '0; state_in = S_ROT;
         end
         S_LVCHK: begin
            if (status.lv_zero) begin
               mdst_in = DST_AH; state_in = S_MSTART;
            end else begin
               state_in = S_LVINIT;
            end
         end
         S_LVINIT: begin
            rjob_in = RJ_LV; cnt_in = '0; state_in = S_ROT;
         end
         S_ROT: begin
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(CORDIC_ITERS - 1)) state_in = S_ZSTORE;
         end
         S_ZSTORE: begin
            case (rjob_ff)
               RJ_H: mdst_in = DST_RH;
               RJ_V: mdst_in = DST_ZE;
               RJ_LH: mdst_in = DST_TH;
               default: mdst_in = DST_TV;
            endcase
            state_in = S_MSTART;
         end
         S_MSTART: begin
            cnt_in = '0; state_in = S_MSTEP;
         end
         S_MSTEP: begin
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(MUL_STEPS - 1)) state_in = S_MSTORE;
         end
         S_MSTORE: begin
            case (mdst_ff)
               DST_RH: begin mdst_in = DST_XP; state_in = S_MSTART; end
               DST_XP: begin mdst_in = DST_YE; state_in = S_MSTART; end
               DST_YE: state_in = S_VCHK;
               DST_ZE: state_in = S_LHCHK;
               DST_TH: state_in = S_LVCHK;
               DST_TV: begin mdst_in = DST_AH; state_in = S_MSTART; end
               DST_AH: begin mdst_in = DST_AV; state_in = S_MSTART; end
               default: state_in = S_OUTW;
            endcase
         end
         S_OUTW: if (status.out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.op  = OP_NONE;
      cmd.idx = cnt_ff[4:0];
      cmd.dst = mdst_ff;
      case (state_ff)
         S_IDLE: if (req_valid) cmd.op = OP_LOAD;
         S_HINIT: cmd.op = OP_H_INIT;
         S_VINIT: cmd.op = OP_V_INIT;
         S_LHINIT: cmd.op = OP_LH_INIT;
         S_LVINIT: cmd.op = OP_LV_INIT;
         S_ROT: cmd.op = OP_ROT;
         S_ZSTORE: begin
            cmd.op = OP_STORE;
            case (rjob_ff)
               RJ_H: cmd.dst = DST_PIH;
               RJ_V: cmd.dst = DST_PIV;
               RJ_LH: cmd.dst = DST_PHIH;
               default: cmd.dst = DST_PHIV;
            endcase
         end
         S_LHCHK: if (status.lh_zero) begin
            cmd.op = OP_STORE; cmd.dst = DST_LH_ZERO;
         end
         S_LVCHK: if (status.lv_zero) begin
            cmd.op = OP_STORE; cmd.dst = DST_LV_ZERO;
         end
         S_MSTART: cmd.op = OP_MUL_START;
         S_MSTEP: cmd.op = OP_MUL_STEP;
         S_MSTORE: cmd.op = OP_STORE;
         S_OUTW: if (status.out_free) cmd.op = OP_OUT;
         default: cmd.op = OP_NONE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

// File: rtl/alg3d_dp.sv
module alg3d_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  alg3d_pkg::cmd_type         cmd,
   output alg3d_pkg::status_type      status,
   input  alg3d_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output alg3d_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_valid,
   input  logic [2:0]                csr_index,
   input  logic [31:0]               csr_data
);
   import alg3d_pkg::*;

   logic [30:0] lah_ff, lav_ff;
   logic [31:0] gh_ff, gv_ff, st_ff;
   logic signed [31:0] crab_h_ff, crab_v_ff;
   logic rsp_valid_ff;
   rsp_payload_type rsp_ff;

   logic signed [63:0] dx_ff, dy_ff, dz_ff;
   logic signed [63:0] rh_ff, xp_ff, ye_ff, ze_ff, th_ff, tv_ff;
   logic signed [31:0] pih_ff, piv_ff, phih_ff, phiv_ff;
   logic signed [63:0] x_ff, y_ff, a_ff, b_ff;
   logic signed [31:0] z_ff;
   logic [63:0]  mul_a_ff, mul_b_ff;
   logic [127:0] prod_ff;
   logic         mul_neg_ff;

   function automatic logic signed [63:0] scl(input logic signed [31:0] hi,
                                              input logic signed [31:0] lo);
      logic signed [32:0] t;
      t = {hi[31], hi} - {lo[31], lo};
      return {{7{t[32]}}, t, 24'b0};
   endfunction

   // CORDIC micro-rotation; the direction follows the sign of y.
   logic signed [63:0] xs, ys, as_, bs;
   logic signed [31:0] at;
   assign xs  = x_ff >>> cmd.idx;
   assign ys  = y_ff >>> cmd.idx;
   assign as_ = a_ff >>> cmd.idx;
   assign bs  = b_ff >>> cmd.idx;
   assign at  = atan_q28(cmd.idx);

   // Multiplier start: pick the operand and its scale factor.
   logic signed [63:0] src;
   logic        is_adapt;
   logic [31:0] gsel;
   logic [63:0] gs;
   always_comb begin
      case (cmd.dst)
         DST_RH: src = x_ff;
         DST_XP, DST_TH, DST_TV: src = a_ff;
         DST_YE, DST_ZE: src = b_ff;
         DST_AH: src = th_ff;
         DST_AV: src = tv_ff;
         default: src = x_ff;
      endcase
   end
   assign is_adapt = (cmd.dst == DST_AH) || (cmd.dst == DST_AV);
   assign gsel = (cmd.dst == DST_AH) ? gh_ff : gv_ff;
   assign gs = gsel * st_ff;

   // Shift-add step of the bit-serial multiplier.
   logic [64:0] psum;
   assign psum = {1'b0, prod_ff[127:64]} + (mul_b_ff[0] ? {1'b0, mul_a_ff} : 65'd0);

   // Gain removal: floor(v * INV_GAIN / 2^30) from the magnitude product.
   logic [127:0] rnd;
   logic signed [63:0] uq, uval;
   assign rnd  = prod_ff + (mul_neg_ff ? 128'h3FFF_FFFF : 128'h0);
   assign uq   = rnd[93:30];
   assign uval = mul_neg_ff ? -uq : uq;

   // Crab estimate update.
   logic [33:0] inc;
   logic signed [33:0] est, est_sum;
   logic signed [31:0] est_new;
   assign inc = (prod_ff[127:92] != '0) ? 34'h1_0000_0000 : {2'b0, prod_ff[91:60]};
   assign est = (cmd.dst == DST_AH) ? 34'(crab_h_ff) : 34'(crab_v_ff);
   assign est_sum = mul_neg_ff ? est - $signed(inc) : est + $signed(inc);
   assign est_new = sat32(est_sum);

   logic signed [63:0] lxh, lxv;
   assign lxh = {9'b0, lah_ff, 24'b0};
   assign lxv = {9'b0, lav_ff, 24'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         lah_ff <= 31'd65536;
         lav_ff <= 31'd65536;
         gh_ff  <= 32'd16777;
         gv_ff  <= 32'd16777;
         st_ff  <= 32'd167772;
      end else if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_LOOKAHEAD_H: lah_ff <= csr_data[30:0];
            REG_LOOKAHEAD_V: lav_ff <= csr_data[30:0];
            REG_GAIN_H: gh_ff <= csr_data;
            REG_GAIN_V: gv_ff <= csr_data;
            REG_STEP: st_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crab_h_ff    <= '0;
         crab_v_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == OP_STORE && cmd.dst == DST_AH) crab_h_ff <= est_new;
         if (cmd.op == OP_STORE && cmd.dst == DST_AV) crab_v_ff <= est_new;
         if (cmd.op == OP_OUT) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            dx_ff  <= scl(req_payload.next_x, req_payload.prev_x);
            dy_ff  <= scl(req_payload.next_y, req_payload.prev_y);
            dz_ff  <= scl(req_payload.next_z, req_payload.prev_z);
            xp_ff  <= scl(req_payload.pos_x, req_payload.prev_x);
            ye_ff  <= scl(req_payload.pos_y, req_payload.prev_y);
            ze_ff  <= scl(req_payload.pos_z, req_payload.prev_z);
            rh_ff  <= '0;
            pih_ff <= '0;
            piv_ff <= '0;
         end
         OP_H_INIT: begin
            // A backward segment is turned around and starts from plus or minus pi.
            if (dx_ff[63]) begin
               x_ff <= -dx_ff; y_ff <= -dy_ff; a_ff <= -xp_ff; b_ff <= -ye_ff;
               z_ff <= dy_ff[63] ? -PI_Q28 : PI_Q28;
            end else begin
               x_ff <= dx_ff; y_ff <= dy_ff; a_ff <= xp_ff; b_ff <= ye_ff;
               z_ff <= '0;
            end
         end
         OP_V_INIT: begin
            x_ff <= rh_ff; y_ff <= -dz_ff; a_ff <= xp_ff; b_ff <= -ze_ff; z_ff <= '0;
         end
         OP_LH_INIT: begin
            x_ff <= lxh; y_ff <= ye_ff; a_ff <= '0; b_ff <= lxh; z_ff <= '0;
         end
         OP_LV_INIT: begin
            x_ff <= lxv; y_ff <= ze_ff; a_ff <= '0; b_ff <= lxv; z_ff <= '0;
         end
         OP_ROT: begin
            if (!y_ff[63]) begin
               x_ff <= x_ff + ys; y_ff <= y_ff - xs;
               a_ff <= a_ff + bs; b_ff <= b_ff - as_;
               z_ff <= z_ff + at;
            end else begin
               x_ff <= x_ff - ys; y_ff <= y_ff + xs;
               a_ff <= a_ff - bs; b_ff <= b_ff + as_;
               z_ff <= z_ff - at;
            end
         end
         OP_MUL_START: begin
            mul_neg_ff <= src[63];
            mul_a_ff   <= src[63] ? 64'(-src) : 64'(src);
            mul_b_ff   <= is_adapt ? gs : {34'b0, INV_GAIN};
            prod_ff    <= '0;
         end
         OP_MUL_STEP: begin
            prod_ff  <= {psum, prod_ff[63:1]};
            mul_b_ff <= {1'b0, mul_b_ff[63:1]};
         end
         OP_STORE: begin
            case (cmd.dst)
               DST_PIH: pih_ff <= z_ff;
               DST_PIV: piv_ff <= z_ff;
               DST_PHIH: phih_ff <= z_ff;
               DST_PHIV: phiv_ff <= z_ff;
               DST_RH: rh_ff <= uval;
               DST_XP: xp_ff <= uval;
               DST_YE: ye_ff <= uval;
               DST_ZE: ze_ff <= -uval;
               DST_TH: th_ff <= uval;
               DST_TV: tv_ff <= uval;
               DST_LH_ZERO: begin phih_ff <= '0; th_ff <= '0; end
               DST_LV_ZERO: begin phiv_ff <= '0; tv_ff <= '0; end
               default: ;
            endcase
         end
         OP_OUT: begin
            rsp_ff.heading_desired <= sat32(34'(pih_ff) - 34'(crab_h_ff) - 34'(phih_ff));
            rsp_ff.pitch_desired   <= sat32(34'(piv_ff) + 34'(crab_v_ff) + 34'(phiv_ff));
         end
         default: ;
      endcase
   end

   assign status.h_zero   = (dx_ff == '0) && (dy_ff == '0);
   assign status.v_skip   = (rh_ff == '0) && (dz_ff == '0);
   assign status.lh_zero  = (lah_ff == '0) && (ye_ff == '0);
   assign status.lv_zero  = (lav_ff == '0) && (ze_ff == '0);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: rtl/adaptive_los_guidance_3d.sv
// Adaptive line-of-sight guidance in three dimensions.
// The req channel carries one item per guidance update: previous waypoint, next
// waypoint and vehicle position. The rsp channel returns one item per request
// with the desired heading and pitch. Both use valid/ready handshakes.
// The csr channel writes lookahead distances, gains and the time step; it is
// always ready and should only be written while no item is in flight.
// The time from acceptance to rsp_valid is longest when the segment has
// horizontal extent and both lookahead passes run. The time is set by up to
// four 28-step CORDIC passes on one shared rotator and two to eight 64-step
// passes of one shared bit-serial multiplier (gain removal and the crab
// estimate updates). One item is processed at a time, and the next one is
// accepted in the cycle after the result is loaded.
// The result sits in an output register, so the next request is accepted while
// it waits; if the receiver stalls, the following item holds in its last step
// until the output register is free.
// Reset clears the crab estimates to zero, restores the register defaults and
// drops rsp_valid.
module adaptive_los_guidance_3d (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  alg3d_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output alg3d_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [2:0]                csr_index,
   input  logic [31:0]               csr_data
);
   import alg3d_pkg::*;

   cmd_type    cmd;
   status_type status;

   alg3d_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   alg3d_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   assign csr_ready = 1'b1;

endmodule

// File: rtl/alg3d_checker.sv
module alg3d_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input alg3d_pkg::rsp_payload_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before the item was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("rsp payload changed while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new item accepted while one is in process");

endmodule

bind adaptive_los_guidance_3d alg3d_checker u_alg3d_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
